/* rtl/wmsu_pkg.sv */
package wmsu_pkg;

	localparam int CHANNELS = 8;
	localparam int CH_W     = 3;

	localparam logic [15:0] FORGET_RESET = 16'd58982;
	localparam logic [32:0] Q32_ONE      = 33'h1_0000_0000;

	// operation codes carried on func
	localparam logic FUNC_ADD    = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	// multiplier operations
	localparam logic OP_MULW = 1'b0;	// round(a*w / 2^32), a 64 bits, w 33 bits
	localparam logic OP_FULL = 1'b1;	// a[32:0]*w, saturated to 64 bits

	typedef struct packed {
		logic        start;
		logic        op;
		logic [63:0] a;
		logic [32:0] w;
	} mul_req_t;

endpackage

/* rtl/wmsu_mul.sv */
module wmsu_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  wmsu_pkg::mul_req_t  req,
	output logic                done,
	output logic [63:0]         res
);

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_FIRST  = 2'd1;
	localparam logic [1:0] PH_SECOND = 2'd2;
	localparam logic [1:0] PH_FIN    = 2'd3;

	logic [1:0]  phase_q;
	logic        done_q;
	logic        op_q;
	logic [63:0] a_q;
	logic [32:0] w_q;
	logic [65:0] prod_q;
	logic [64:0] lo_q;
	logic [63:0] res_q;

	logic [32:0] mop;
	logic [65:0] prod;
	logic [64:0] lo_sum;
	logic [65:0] sum;

	always_comb begin
		if (phase_q == PH_FIRST) begin
			mop = (op_q == wmsu_pkg::OP_FULL) ? a_q[32:0] : {1'b0, a_q[31:0]};
		end else begin
			mop = {1'b0, a_q[63:32]};
		end
	end

	assign prod   = 66'(mop) * 66'(w_q);
	assign lo_sum = lo_q + 65'h0_8000_0000;
	assign sum    = prod_q + {33'b0, lo_sum[64:32]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (phase_q == PH_FIN);
			case (phase_q)
				PH_IDLE: begin
					if (req.start) begin
						phase_q <= PH_FIRST;
					end
				end
				PH_FIRST: begin
					phase_q <= (op_q == wmsu_pkg::OP_FULL) ? PH_FIN : PH_SECOND;
				end
				PH_SECOND: begin
					phase_q <= PH_FIN;
				end
				PH_FIN: begin
					phase_q <= PH_IDLE;
				end
				default: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			PH_IDLE: begin
				if (req.start) begin
					op_q <= req.op;
					a_q  <= req.a;
					w_q  <= req.w;
				end
			end
			PH_FIRST: begin
				prod_q <= prod;
			end
			PH_SECOND: begin
				lo_q   <= prod_q[64:0];
				prod_q <= prod;
			end
			PH_FIN: begin
				if (op_q == wmsu_pkg::OP_FULL) begin
					res_q <= (prod_q[65:64] != 2'b00) ? '1 : prod_q[63:0];
				end else begin
					res_q <= sum[63:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

/* rtl/wmsu_div.sv */
module wmsu_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [33:0] den,
	output logic        done,
	output logic [32:0] quo
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [33:0] rem_q;
	logic [63:0] num_q;
	logic [63:0] q_q;
	logic [33:0] den_q;

	logic [34:0] trial;
	logic [34:0] diff;
	logic        ge;

	assign trial = {rem_q, num_q[63]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 6'd63);
			if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
				end
			end else if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			rem_q <= ge ? diff[33:0] : trial[33:0];
			num_q <= {num_q[62:0], 1'b0};
			q_q   <= {q_q[62:0], ge};
		end else if (start) begin
			rem_q <= '0;
			num_q <= num;
			den_q <= den;
			q_q   <= '0;
		end
	end

	// weights never exceed one
	assign quo  = (q_q > {31'b0, wmsu_pkg::Q32_ONE}) ? wmsu_pkg::Q32_ONE : q_q[32:0];
	assign done = done_q;

endmodule

/* rtl/wmsu_sqrt.sv */
module wmsu_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] v,
	output logic        done,
	output logic [31:0] root
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [63:0] v_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;

	logic [63:0] trial;
	logic        ge;

	assign trial = res_q + bit_q;
	assign ge    = (v_q >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 5'd31);
			if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
				end
			end else if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			v_q   <= ge ? v_q - trial : v_q;
			res_q <= ge ? (res_q >> 1) + bit_q : res_q >> 1;
			bit_q <= bit_q >> 2;
		end else if (start) begin
			v_q   <= v;
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end
	end

	assign root = res_q[31:0];
	assign done = done_q;

endmodule

/* rtl/weighted_mean_std_update_unit.sv */
// Forget-weighted running mean and standard deviation for eight channels.
// Each input beat adds a Q16.16 sample to one channel (func 0) or removes
// the weighted contribution of the oldest sample (func 1); sample_count is
// the sequence length before the step. An add with count 0 restarts the
// channel, a remove with count 0 or 1 clears it. The output beat carries
// the channel's new mean (signed Q16.16, saturated) and deviation
// (unsigned Q16.16, saturated). forget_rate (Q0.16) is written through
// cfg_wen/cfg_wdata; the user must write it only while the unit is idle,
// which the unit does not enforce. It resets to 0.9. One beat is handled
// at a time: in_stall stays high from acceptance until the result is
// loaded into the output register, which can still be waiting on
// out_stall while the next beat is accepted. An item raises the forget
// factor to a power on the shared multiplier, two multiplies per set bit
// and one per clear bit up to the highest set bit of the exponent (the
// count on an add, count minus one on a remove), then the 64-step
// restoring divider, five more multiplies on an add or up to three on a
// remove, and the 32-step square root. A short remove runs only the root.
module weighted_mean_std_update_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               func,
	input  logic [2:0]         channel,
	input  logic signed [31:0] sample,
	input  logic [15:0]        sample_count,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] run_mean,
	output logic [31:0]        new_std
);

	// sequencer states
	localparam logic [4:0] ST_IDLE   = 5'd0;
	localparam logic [4:0] ST_LOAD   = 5'd1;
	localparam logic [4:0] ST_WAIT   = 5'd2;
	localparam logic [4:0] ST_POW0   = 5'd3;
	localparam logic [4:0] ST_PLOOP  = 5'd4;
	localparam logic [4:0] ST_PRES   = 5'd5;
	localparam logic [4:0] ST_PSQ    = 5'd6;
	localparam logic [4:0] ST_PSQD   = 5'd7;
	localparam logic [4:0] ST_POWEND = 5'd8;
	localparam logic [4:0] ST_ADEN   = 5'd9;
	localparam logic [4:0] ST_RDEN   = 5'd10;
	localparam logic [4:0] ST_WSET   = 5'd11;
	localparam logic [4:0] ST_MEAN   = 5'd12;
	localparam logic [4:0] ST_A_T1   = 5'd13;
	localparam logic [4:0] ST_A_WW   = 5'd14;
	localparam logic [4:0] ST_A_U    = 5'd15;
	localparam logic [4:0] ST_A_T2   = 5'd16;
	localparam logic [4:0] ST_R_K    = 5'd17;
	localparam logic [4:0] ST_R_T    = 5'd18;
	localparam logic [4:0] ST_FIN    = 5'd19;

	// control
	logic [4:0]  state_q;
	logic [4:0]  ret_q;
	logic        out_valid_q;
	logic [15:0] forget_q;

	// per-channel statistics
	logic [31:0] mean_store_q [wmsu_pkg::CHANNELS];
	logic [31:0] std_store_q  [wmsu_pkg::CHANNELS];

	// item and working registers
	logic                      func_q;
	logic [wmsu_pkg::CH_W-1:0] ch_q;
	logic [31:0]               x_q;
	logic [15:0]               n_q;
	logic [31:0]               m_q;
	logic                      neg_q;
	logic [32:0]               mag_q;
	logic [63:0]               var_q;
	logic [32:0]               pres_q;		// power result, Q32
	logic [31:0]               pbase_q;		// running square of f
	logic [15:0]               exp_q;
	logic [32:0]               w1_q;		// wa on add, r on remove
	logic [32:0]               w2_q;		// wb
	logic [63:0]               tmp_q;
	logic [31:0]               nm_q;
	logic [31:0]               run_mean_q;
	logic [31:0]               new_std_q;

	// shared units
	wmsu_pkg::mul_req_t mul_req;
	logic               mul_done;
	logic [63:0]        mul_res;
	logic               div_start;
	logic [63:0]        div_num;
	logic [33:0]        div_den;
	logic               div_done;
	logic [32:0]        div_quo;
	logic               sqrt_start;
	logic [63:0]        sqrt_v;
	logic               sqrt_done;
	logic [31:0]        sqrt_root;
	logic               any_done;

	// datapath helpers
	logic        is_add;
	logic        short_rm;
	logic        restart;
	logic [31:0] m_ld;
	logic [31:0] s_ld;
	logic [32:0] d33;
	logic [32:0] mag33;
	logic [31:0] fq;
	logic [32:0] omf;
	logic [33:0] den_add;
	logic [32:0] g33;
	logic [34:0] m35;
	logic [34:0] s35;
	logic [34:0] nm35;
	logic [31:0] nm_sat;
	logic [64:0] sum_t;
	logic [63:0] nv_sat;
	logic        k_ge;
	logic        accept;
	logic        out_free;
	logic        load_out;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign load_out = (state_q == ST_FIN) && out_free;
	assign any_done = mul_done || div_done || sqrt_done;

	assign is_add   = (func_q == wmsu_pkg::FUNC_ADD);
	assign short_rm = !is_add && (n_q[15:1] == 15'd0);
	assign restart  = is_add && (n_q == 16'd0);

	assign m_ld  = restart ? 32'd0 : mean_store_q[ch_q];
	assign s_ld  = restart ? 32'd0 : std_store_q[ch_q];
	assign d33   = {x_q[31], x_q} - {m_ld[31], m_ld};
	assign mag33 = d33[32] ? (33'd0 - d33) : d33;

	assign fq  = {forget_q, 16'h0000};
	assign omf = wmsu_pkg::Q32_ONE - {1'b0, fq};

	// add: den = omf + a, rounded quotient a*2^32/den
	assign den_add = {1'b0, omf} + {2'b00, mul_res[31:0]};
	// remove: g = 1 - f^(n-1)
	assign g33 = wmsu_pkg::Q32_ONE - pres_q;

	// mean update: step comes back from the multiplier
	assign m35  = {{3{m_q[31]}}, m_q};
	assign s35  = {2'b00, mul_res[32:0]};
	assign nm35 = (is_add != neg_q) ? m35 + s35 : m35 - s35;
	always_comb begin
		if (nm35[34:31] == 4'b0000 || nm35[34:31] == 4'b1111) begin
			nm_sat = nm35[31:0];
		end else begin
			nm_sat = nm35[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
	end

	// saturating variance sum
	assign sum_t  = {1'b0, tmp_q} + {1'b0, mul_res};
	assign nv_sat = sum_t[64] ? '1 : sum_t[63:0];
	assign k_ge   = (mul_res >= var_q);

	// unit requests
	always_comb begin
		mul_req.start = 1'b0;
		mul_req.op    = wmsu_pkg::OP_MULW;
		mul_req.a     = '0;
		mul_req.w     = '0;
		div_start     = 1'b0;
		div_num       = '0;
		div_den       = '0;
		sqrt_start    = 1'b0;
		sqrt_v        = '0;
		case (state_q)
			ST_LOAD: begin
				if (short_rm) begin
					sqrt_start = 1'b1;
				end else begin
					mul_req.start = 1'b1;
					mul_req.op    = wmsu_pkg::OP_FULL;
					mul_req.a     = {32'b0, s_ld};
					mul_req.w     = {1'b0, s_ld};
				end
			end
			ST_PLOOP: begin
				if (exp_q != 16'd0 && exp_q[0]) begin
					mul_req.start = 1'b1;
					mul_req.a     = {31'b0, pres_q};
					mul_req.w     = {1'b0, pbase_q};
				end
			end
			ST_PSQ: begin
				mul_req.start = 1'b1;
				mul_req.a     = {32'b0, pbase_q};
				mul_req.w     = {1'b0, pbase_q};
			end
			ST_POWEND: begin
				mul_req.start = 1'b1;
				if (is_add) begin
					mul_req.a = {32'b0, fq};
					mul_req.w = wmsu_pkg::Q32_ONE - pres_q;
				end else begin
					mul_req.a = {31'b0, omf};
					mul_req.w = pres_q;
				end
			end
			ST_ADEN: begin
				div_start = 1'b1;
				div_num   = {mul_res[31:0], 32'b0} + {31'b0, den_add[33:1]};
				div_den   = den_add;
			end
			ST_RDEN: begin
				div_start = 1'b1;
				div_num   = {mul_res[31:0], 32'b0} + {32'b0, g33[32:1]};
				div_den   = {1'b0, g33};
			end
			ST_WSET: begin
				mul_req.start = 1'b1;
				mul_req.a     = {31'b0, mag_q};
				mul_req.w     = is_add ? wmsu_pkg::Q32_ONE - div_quo : div_quo;
			end
			ST_MEAN: begin
				mul_req.start = 1'b1;
				if (is_add) begin
					mul_req.a = var_q;
					mul_req.w = w1_q;
				end else begin
					mul_req.op = wmsu_pkg::OP_FULL;
					mul_req.a  = {31'b0, mul_res[32:0]};
					mul_req.w  = mag_q;
				end
			end
			ST_A_T1: begin
				mul_req.start = 1'b1;
				mul_req.a     = {31'b0, w1_q};
				mul_req.w     = w2_q;
			end
			ST_A_WW: begin
				mul_req.start = 1'b1;
				mul_req.a     = {31'b0, mag_q};
				mul_req.w     = mul_res[32:0];
			end
			ST_A_U: begin
				mul_req.start = 1'b1;
				mul_req.op    = wmsu_pkg::OP_FULL;
				mul_req.a     = {31'b0, mul_res[32:0]};
				mul_req.w     = mag_q;
			end
			ST_A_T2: begin
				sqrt_start = 1'b1;
				sqrt_v     = nv_sat;
			end
			ST_R_K: begin
				// negative variance clamps to zero
				if (k_ge) begin
					sqrt_start = 1'b1;
				end else begin
					mul_req.start = 1'b1;
					mul_req.a     = var_q - mul_res;
					mul_req.w     = w1_q;
				end
			end
			ST_R_T: begin
				sqrt_start = 1'b1;
				sqrt_v     = nv_sat;
			end
			default: begin
			end
		endcase
	end

	wmsu_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.done   (mul_done),
		.res    (mul_res)
	);

	wmsu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	wmsu_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.v      (sqrt_v),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	// sequencer, output handshake, config and channel store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			out_valid_q <= 1'b0;
			forget_q    <= wmsu_pkg::FORGET_RESET;
			for (int i = 0; i < wmsu_pkg::CHANNELS; i++) begin
				mean_store_q[i] <= '0;
				std_store_q[i]  <= '0;
			end
		end else begin
			if (cfg_wen) begin
				forget_q <= cfg_wdata;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_WAIT;
					ret_q   <= short_rm ? ST_FIN : ST_POW0;
				end
				ST_WAIT: begin
					if (any_done) begin
						state_q <= ret_q;
					end
				end
				ST_POW0: begin
					state_q <= ST_PLOOP;
				end
				ST_PLOOP: begin
					if (exp_q == 16'd0) begin
						state_q <= ST_POWEND;
					end else if (exp_q[0]) begin
						state_q <= ST_WAIT;
						ret_q   <= ST_PRES;
					end else begin
						state_q <= ST_PSQ;
					end
				end
				ST_PRES: begin
					state_q <= ST_PSQ;
				end
				ST_PSQ: begin
					state_q <= ST_WAIT;
					ret_q   <= ST_PSQD;
				end
				ST_PSQD: begin
					state_q <= ST_PLOOP;
				end
				ST_POWEND: begin
					state_q <= ST_WAIT;
					ret_q   <= is_add ? ST_ADEN : ST_RDEN;
				end
				ST_ADEN, ST_RDEN: begin
					state_q <= ST_WAIT;
					ret_q   <= ST_WSET;
				end
				ST_WSET: begin
					state_q <= ST_WAIT;
					ret_q   <= ST_MEAN;
				end
				ST_MEAN: begin
					state_q <= ST_WAIT;
					ret_q   <= is_add ? ST_A_T1 : ST_R_K;
				end
				ST_A_T1: begin
					state_q <= ST_WAIT;
					ret_q   <= ST_A_WW;
				end
				ST_A_WW: begin
					state_q <= ST_WAIT;
					ret_q   <= ST_A_U;
				end
				ST_A_U: begin
					state_q <= ST_WAIT;
					ret_q   <= ST_A_T2;
				end
				ST_A_T2, ST_R_T: begin
					state_q <= ST_WAIT;
					ret_q   <= ST_FIN;
				end
				ST_R_K: begin
					state_q <= ST_WAIT;
					ret_q   <= k_ge ? ST_FIN : ST_R_T;
				end
				ST_FIN: begin
					if (out_free) begin
						mean_store_q[ch_q] <= nm_q;
						std_store_q[ch_q]  <= sqrt_root;
						state_q            <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					func_q <= func;
					ch_q   <= channel;
					x_q    <= sample;
					n_q    <= sample_count;
				end
			end
			ST_LOAD: begin
				m_q   <= m_ld;
				neg_q <= d33[32];
				mag_q <= mag33;
				nm_q  <= '0;
			end
			ST_POW0: begin
				var_q   <= mul_res;
				pres_q  <= wmsu_pkg::Q32_ONE;
				pbase_q <= fq;
				exp_q   <= is_add ? n_q : n_q - 16'd1;
			end
			ST_PRES: begin
				pres_q <= mul_res[32:0];
			end
			ST_PSQD: begin
				pbase_q <= mul_res[31:0];
				exp_q   <= exp_q >> 1;
			end
			ST_WSET: begin
				w1_q <= div_quo;
				w2_q <= wmsu_pkg::Q32_ONE - div_quo;
			end
			ST_MEAN: begin
				nm_q <= nm_sat;
			end
			ST_A_T1: begin
				tmp_q <= mul_res;
			end
			ST_R_K: begin
				tmp_q <= var_q - mul_res;
			end
			ST_FIN: begin
				if (out_free) begin
					run_mean_q <= nm_q;
					new_std_q  <= sqrt_root;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign run_mean  = run_mean_q;
	assign new_std   = new_std_q;

	// an accepted beat always starts with the store read
	a_accept_load: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_LOAD))
		else $error("accepted beat did not enter load");

	// only one shared unit finishes at a time
	a_one_done: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({mul_done, div_done, sqrt_done}))
		else $error("more than one unit done");

	// multiplier results arrive only while the sequencer waits
	a_mul_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_WAIT))
		else $error("multiplier done outside wait");

	// a finished item reaches the output register once the slot is free
	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_free) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("result not delivered");

endmodule

/* sim/testbench.sv */
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam bit [63:0] ONE_Q32   = 64'h1_0000_0000;
	localparam bit [63:0] LOW_WORD  = 64'hFFFF_FFFF;
	localparam bit [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam int        STALL_CAP = 20000;	// cycles without any beat
	localparam int        TAIL      = 400;	// longer than the worst item

	typedef struct packed {
		bit [31:0] mean;
		bit [31:0] std;
	} stats_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_wen;
	logic [15:0]        cfg_wdata;
	logic               in_valid;
	logic               in_stall;
	logic               func;
	logic [2:0]         channel;
	logic signed [31:0] sample;
	logic [15:0]        sample_count;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] run_mean;
	logic [31:0]        new_std;

	weighted_mean_std_update_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.channel      (channel),
		.sample       (sample),
		.sample_count (sample_count),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.run_mean     (run_mean),
		.new_std      (new_std)
	);

	// shadow copy of the unit's state
	bit [15:0] rate_shadow;
	bit [31:0] mean_shadow [wmsu_pkg::CHANNELS];
	bit [31:0] std_shadow  [wmsu_pkg::CHANNELS];

	stats_t pending_stats[$];
	int     mismatches;
	int     idle_cycles;
	int     send_gap_pct;
	int     recv_stall_pct;
	int     seq_len [wmsu_pkg::CHANNELS];	// running sequence length per channel

	// round(a*w / 2^32), halves up, 64-bit wrap like the datapath
	function automatic bit [63:0] q32_scale(bit [63:0] a, bit [63:0] w);
		bit [63:0] hi;
		bit [63:0] lo;
		hi = a >> 32;
		lo = a & LOW_WORD;
		return hi * w + ((lo * w + 64'h8000_0000) >> 32);
	endfunction

	function automatic bit [63:0] sat_product(bit [63:0] a, bit [63:0] b);
		bit [127:0] p;
		p = {64'b0, a} * {64'b0, b};
		return (p[127:64] != 0) ? ALL_ONES : p[63:0];
	endfunction

	function automatic bit [63:0] sat_sum(bit [63:0] a, bit [63:0] b);
		bit [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? ALL_ONES : s[63:0];
	endfunction

	// square-and-multiply from the lowest exponent bit up
	function automatic bit [63:0] forget_power(bit [63:0] base, bit [15:0] k);
		bit [63:0] acc;
		acc = ONE_Q32;
		for (int i = 0; i < 16; i++) begin
			if (k[i])
				acc = q32_scale(acc, base);
			base = q32_scale(base, base);
		end
		return acc;
	endfunction

	function automatic bit [31:0] int_sqrt(bit [63:0] v);
		bit [63:0] root;
		bit [63:0] b;
		root = 0;
		b = 64'h1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= root + b) begin
				v = v - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root[31:0];
	endfunction

	// next statistics of one channel; updates the shadow state
	function automatic stats_t update_stats(bit f, bit [2:0] ch, bit [31:0] smp,
			bit [15:0] cnt);
		longint    m, d, nm, x;
		bit [63:0] s, variance, mag, nv, fq, omf;
		bit [63:0] p, a, den, wa, wb, t1, t2, p0, e, g, r, stp, k, t;
		stats_t    res;
		fq  = {32'b0, rate_shadow, 16'b0};
		omf = ONE_Q32 - fq;
		x   = longint'($signed(smp));
		m   = longint'($signed(mean_shadow[ch]));
		s   = {32'b0, std_shadow[ch]};
		if (f == wmsu_pkg::FUNC_ADD) begin
			if (cnt == 0) begin	// restart of the sequence
				m = 0;
				s = 0;
			end
			variance = s * s;
			p   = forget_power(fq, cnt);
			a   = q32_scale(fq, ONE_Q32 - p);
			den = omf + a;
			wa  = ((a << 32) + den / 2) / den;
			if (wa > ONE_Q32)
				wa = ONE_Q32;
			wb  = ONE_Q32 - wa;
			d   = x - m;
			mag = (d < 0) ? 64'(-d) : 64'(d);
			nm  = (d < 0) ? m - longint'(q32_scale(mag, wb))
			              : m + longint'(q32_scale(mag, wb));
			t1  = q32_scale(variance, wa);
			t2  = sat_product(q32_scale(mag, q32_scale(wa, wb)), mag);
			nv  = sat_sum(t1, t2);
		end else if (cnt <= 1) begin	// short sequence clears the channel
			nm = 0;
			nv = 0;
		end else begin
			variance = s * s;
			p0 = forget_power(fq, cnt - 16'd1);
			e  = q32_scale(omf, p0);
			g  = ONE_Q32 - p0;
			r  = ((e << 32) + g / 2) / g;
			if (r > ONE_Q32)
				r = ONE_Q32;
			d   = x - m;
			mag = (d < 0) ? 64'(-d) : 64'(d);
			stp = q32_scale(mag, r);
			nm  = (d < 0) ? m + longint'(stp) : m - longint'(stp);
			k   = sat_product(stp, mag);
			if (k >= variance) begin	// negative variance clamps to zero
				nv = 0;
			end else begin
				t  = variance - k;
				nv = sat_sum(t, q32_scale(t, r));
			end
		end
		if (nm > 64'sd2147483647)
			nm = 64'sd2147483647;
		if (nm < -64'sd2147483648)
			nm = -64'sd2147483648;
		mean_shadow[ch] = nm[31:0];
		std_shadow[ch]  = int_sqrt(nv);
		res.mean = mean_shadow[ch];
		res.std  = std_shadow[ch];
		return res;
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// result side: random stall, compare against the oldest expectation
	always @(posedge clk) begin
		stats_t want;
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		if (arst_n && out_valid && !out_stall) begin
			if (pending_stats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: mean %h std %h", run_mean, new_std);
			end else begin
				want = pending_stats.pop_front();
				if (run_mean !== want.mean || new_std !== want.std) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: mean exp %h got %h, std exp %h got %h",
							want.mean, run_mean, want.std, new_std);
				end
			end
		end
	end

	// watchdog on cycles where neither side moves a beat
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_CAP) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// one input beat; optional idle cycles first, prediction on acceptance
	task automatic send_beat(bit f, bit [2:0] ch, bit [31:0] smp, bit [15:0] cnt);
		stats_t exp_stats;
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		func         <= f;
		channel      <= ch;
		sample       <= smp;
		sample_count <= cnt;
		do
			@(posedge clk);
		while (in_stall);
		exp_stats = update_stats(f, ch, smp, cnt);
		pending_stats.insert(pending_stats.size(), exp_stats);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (pending_stats.size() != 0)
			@(posedge clk);
	endtask

	// register write only with the unit idle
	task automatic set_rate(bit [15:0] v);
		drain();
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		rate_shadow = v;
	endtask

	function automatic bit [31:0] pick_sample();
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
	endfunction

	// extremes of every field, both operations, the clearing cases
	task automatic test_directed;
		send_beat(wmsu_pkg::FUNC_ADD,    3'd0, 32'h7FFF_FFFF, 16'd0);
		send_beat(wmsu_pkg::FUNC_ADD,    3'd0, 32'h8000_0000, 16'd1);
		send_beat(wmsu_pkg::FUNC_ADD,    3'd0, 32'h7FFF_FFFF, 16'd2);
		send_beat(wmsu_pkg::FUNC_REMOVE, 3'd0, 32'h8000_0000, 16'd3);
		send_beat(wmsu_pkg::FUNC_REMOVE, 3'd0, 32'h0001_0000, 16'd2);
		send_beat(wmsu_pkg::FUNC_REMOVE, 3'd0, 32'h0000_0000, 16'd1);
		send_beat(wmsu_pkg::FUNC_ADD,    3'd7, 32'h0003_0000, 16'd0);
		send_beat(wmsu_pkg::FUNC_ADD,    3'd7, 32'hFFFD_0000, 16'd65535);
		send_beat(wmsu_pkg::FUNC_REMOVE, 3'd7, 32'h0005_8000, 16'd65535);
		send_beat(wmsu_pkg::FUNC_REMOVE, 3'd7, 32'h0000_0000, 16'd0);
		send_beat(wmsu_pkg::FUNC_ADD,    3'd5, 32'hFFFF_FFFF, 16'd32768);
		send_beat(wmsu_pkg::FUNC_REMOVE, 3'd5, 32'h0000_0001, 16'd32768);
		send_beat(wmsu_pkg::FUNC_ADD,    3'd2, 32'h8000_0000, 16'd0);
		send_beat(wmsu_pkg::FUNC_ADD,    3'd2, 32'h7FFF_FFFF, 16'd1);
	endtask

	// short add/remove runs at the edges of the forget factor, zero included
	task automatic test_rate_extremes;
		bit [15:0] rates [4] = '{16'd1, 16'd65535, 16'd0, 16'd32768};
		foreach (rates[i]) begin
			set_rate(rates[i]);
			send_beat(wmsu_pkg::FUNC_ADD,    3'd1, 32'h0002_0000, 16'd0);
			send_beat(wmsu_pkg::FUNC_ADD,    3'd1, 32'hFFFE_0000, 16'd1);
			send_beat(wmsu_pkg::FUNC_ADD,    3'd1, 32'h0010_0000, 16'd2);
			send_beat(wmsu_pkg::FUNC_REMOVE, 3'd1, 32'h0002_0000, 16'd3);
			send_beat(wmsu_pkg::FUNC_REMOVE, 3'd1, 32'h7FFF_FFFF, 16'd2);
		end
	endtask

	// mostly well-formed per-channel sequences, some restarts and noise
	task automatic test_random(int count, int gap_pct, int stall_pct, bit [15:0] rate);
		int        sel;
		bit [2:0]  ch;
		set_rate(rate);
		send_gap_pct   = gap_pct;
		recv_stall_pct = stall_pct;
		repeat (count) begin
			sel = int'($urandom_range(0, 99));
			ch  = 3'($urandom_range(0, wmsu_pkg::CHANNELS - 1));
			if (sel < 45) begin
				send_beat(wmsu_pkg::FUNC_ADD, ch, pick_sample(), 16'(seq_len[ch]));
				seq_len[ch]++;
			end else if (sel < 65) begin
				send_beat(wmsu_pkg::FUNC_REMOVE, ch, pick_sample(), 16'(seq_len[ch]));
				if (seq_len[ch] > 0)
					seq_len[ch]--;
			end else if (sel < 75) begin
				send_beat(wmsu_pkg::FUNC_ADD, ch, pick_sample(), 16'd0);
				seq_len[ch] = 1;
			end else begin
				// arbitrary beat; sequence bookkeeping no longer tracks it
				send_beat(1'($urandom_range(0, 1)), ch, $urandom,
					16'($urandom_range(0, 65535)));
				seq_len[ch] = int'($urandom_range(0, 40));
			end
		end
		drain();
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_wen        = 1'b0;
		cfg_wdata      = '0;
		in_valid       = 1'b0;
		func           = wmsu_pkg::FUNC_ADD;
		channel        = '0;
		sample         = '0;
		sample_count   = '0;
		out_stall      = 1'b0;
		send_gap_pct   = 0;
		recv_stall_pct = 0;
		mismatches     = 0;
		idle_cycles    = 0;
		rate_shadow    = wmsu_pkg::FORGET_RESET;
		foreach (mean_shadow[i]) begin
			mean_shadow[i] = '0;
			std_shadow[i]  = '0;
			seq_len[i]     = 0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_rate_extremes();
		test_random(470, 0,  0,  16'd58982);
		test_random(470, 57, 0,  16'd65535);
		test_random(470, 0,  57, 16'd1);
		test_random(470, 35, 35, 16'($urandom_range(1, 65535)));

		drain();
		repeat (TAIL) @(posedge clk);
		if (mismatches == 0 && pending_stats.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
